// ===== hw/rtl/cags_pkg.sv =====
`timescale 1ns / 1ps
package cags_pkg;

   localparam int MAX_COLS_DEFAULT = 64;
   localparam int MAX_ROWS         = 1024;

   localparam int ROW_CFG_W  = 11;
   localparam int COL_CFG_W  = 7;
   localparam int LIMIT_W    = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 11;

   localparam int RESET_ROWS  = 40;
   localparam int RESET_COLS  = 40;
   localparam int RESET_BIRTH = 5;
   localparam int RESET_DEATH = 3;

   localparam int WINDOW_W = 9;
   localparam int COUNT_W  = 4;

   localparam int Q_DEPTH   = 3;
   localparam int Q_COUNT_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_COUNT   = 2'd0,
      CSR_COL_COUNT   = 2'd1,
      CSR_BIRTH_LIMIT = 2'd2,
      CSR_DEATH_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic next_alive;
      logic last_of_frame;
      logic dropped;
   } result_type;

   typedef struct packed {
      logic first_col;
      logic last_col;
      logic first_row;
      logic last_row;
   } border_type;

endpackage

// ===== hw/rtl/cags_ram.sv =====
`timescale 1ns / 1ps
module cags_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cags_rule.sv =====
`timescale 1ns / 1ps
module cags_rule (
   input  logic [cags_pkg::WINDOW_W-1:0] window,
   input  cags_pkg::border_type          border,
   input  logic [cags_pkg::LIMIT_W-1:0]  birth_limit,
   input  logic [cags_pkg::LIMIT_W-1:0]  death_limit,
   output logic                          next_alive
);

   logic [cags_pkg::WINDOW_W-1:0] live;
   logic [cags_pkg::COUNT_W-1:0]  count;
   logic                          centre;

   // Window bit 3*col + row: col 0 is left, row 0 is the top row.
   always_comb begin
      live = window;
      live[4] = 1'b0;
      if (border.first_col) begin
         live[2:0] = 3'b000;
      end
      if (border.last_col) begin
         live[8:6] = 3'b000;
      end
      if (border.first_row) begin
         live[0] = 1'b0;
         live[3] = 1'b0;
         live[6] = 1'b0;
      end
      if (border.last_row) begin
         live[2] = 1'b0;
         live[5] = 1'b0;
         live[8] = 1'b0;
      end
      count = '0;
      for (int i = 0; i < cags_pkg::WINDOW_W; i++) begin
         count = count + cags_pkg::COUNT_W'(live[i]);
      end
      centre = window[4];
      if (!centre && count >= birth_limit) begin
         next_alive = 1'b1;
      end else if (centre && count < death_limit) begin
         next_alive = 1'b0;
      end else begin
         next_alive = centre;
      end
   end

endmodule

// ===== hw/rtl/cags_rsp_queue.sv =====
`timescale 1ns / 1ps
module cags_rsp_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  cags_pkg::result_type            push_data,
   input  logic                            pop,
   output logic                            not_empty,
   output cags_pkg::result_type            head,
   output logic [cags_pkg::Q_COUNT_W-1:0]  count
);

   cags_pkg::result_type             q_ff [cags_pkg::Q_DEPTH];
   cags_pkg::result_type             q_in [cags_pkg::Q_DEPTH];
   logic [cags_pkg::Q_COUNT_W-1:0]   count_ff;
   logic [cags_pkg::Q_COUNT_W-1:0]   count_in;

   always_comb begin
      q_in = q_ff;
      count_in = count_ff;
      if (pop) begin
         for (int i = 0; i < cags_pkg::Q_DEPTH - 1; i++) begin
            q_in[i] = q_ff[i+1];
         end
         count_in = count_ff - cags_pkg::Q_COUNT_W'(1);
      end
      if (push) begin
         for (int i = 0; i < cags_pkg::Q_DEPTH; i++) begin
            if (cags_pkg::Q_COUNT_W'(i) == count_in) begin
               q_in[i] = push_data;
            end
         end
         count_in = count_in + cags_pkg::Q_COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign not_empty = count_ff != '0;
   assign head = q_ff[0];
   assign count = count_ff;

endmodule

// ===== hw/rtl/cave_automaton_generation_step.sv =====
`timescale 1ns / 1ps
// One generation of a life-like cave automaton over a raster-order grid, one cell per req beat.
// Each rsp beat carries the new state of the cell one row and one cell behind the input, so
// the first col_count + 1 cells of a frame give no result; after the frame's last cell,
// send col_count + 1 beats with req_flush set to drain the rest, the final one marked with
// rsp_last_of_frame. A cell sent while that drain is pending is dropped and answered with
// rsp_dropped set. The two rows above the input live in one 2-bit wide RAM of MAX_COLS
// entries, read once and written once per cell, with a one-entry bypass for single-column
// frames; rows are always written before they are used, so the RAM needs no clearing after
// reset. The block takes one beat per clock while the output queue has room, limited by
// that single RAM read per cell; a result reaches the rsp side through the second-stage
// registers and a three-entry output queue. Write the configuration registers only while
// the block is idle; writing row_count or col_count restarts the frame.
module cave_automaton_generation_step #(
   parameter int MAX_COLS = cags_pkg::MAX_COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cell_alive,
   input  logic                              req_flush,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_next_alive,
   output logic                              rsp_last_of_frame,
   output logic                              rsp_dropped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cags_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cags_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int CW   = $clog2(MAX_COLS + 1);
   localparam int AW   = $clog2(MAX_COLS);
   localparam int DW   = $clog2(MAX_COLS + 2);
   localparam int RW   = cags_pkg::ROW_CFG_W;
   localparam int CMPW = (CW > cags_pkg::COL_CFG_W) ? CW : cags_pkg::COL_CFG_W;

   // configuration
   logic [RW-1:0]                     row_count_ff;
   logic [cags_pkg::COL_CFG_W-1:0]    col_count_ff;
   logic [cags_pkg::LIMIT_W-1:0]      birth_ff;
   logic [cags_pkg::LIMIT_W-1:0]      death_ff;
   logic                              csr_write;
   logic                              geom_write;
   cags_pkg::csr_index_type           csr_sel;

   logic [RW-1:0]                     rows_eff;
   logic [CW-1:0]                     cols_eff;
   logic [CMPW-1:0]                   col_wide;

   // frame position
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [DW-1:0] drain_ff, drain_in;

   logic accept;
   logic draining;
   logic take_drop;
   logic take_proc;
   logic ci_last;
   logic ri_last;
   logic emit;
   logic frame_last;
   cags_pkg::border_type border;

   // second stage
   logic                 s1_valid_ff;
   logic                 s1_mem_ff;
   logic                 s1_dropped_ff;
   logic                 s1_last_ff;
   logic                 s1_bit_ff;
   logic [AW-1:0]        s1_addr_ff;
   cags_pkg::border_type s1_border_ff;

   logic [1:0]    ram_rd_data;
   logic [1:0]    line_rd;
   logic [1:0]    line_wr;
   logic          fwd_valid_ff;
   logic [AW-1:0] fwd_addr_ff;
   logic [1:0]    fwd_data_ff;

   logic [cags_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic                          rule_alive;
   cags_pkg::result_type          s1_result;
   cags_pkg::result_type          q_head;
   logic                          q_not_empty;
   logic [cags_pkg::Q_COUNT_W-1:0] q_count;
   logic                          pop;

   // ---------------- configuration ----------------
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign csr_sel    = cags_pkg::csr_index_type'(csr_index);
   assign geom_write = csr_write
                       && (csr_sel == cags_pkg::CSR_ROW_COUNT
                           || csr_sel == cags_pkg::CSR_COL_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= RW'(cags_pkg::RESET_ROWS);
         col_count_ff <= cags_pkg::COL_CFG_W'(cags_pkg::RESET_COLS);
         birth_ff     <= cags_pkg::LIMIT_W'(cags_pkg::RESET_BIRTH);
         death_ff     <= cags_pkg::LIMIT_W'(cags_pkg::RESET_DEATH);
      end else if (csr_write) begin
         unique case (csr_sel)
            cags_pkg::CSR_ROW_COUNT:   row_count_ff <= csr_data[RW-1:0];
            cags_pkg::CSR_COL_COUNT:   col_count_ff <= csr_data[cags_pkg::COL_CFG_W-1:0];
            cags_pkg::CSR_BIRTH_LIMIT: birth_ff <= csr_data[cags_pkg::LIMIT_W-1:0];
            cags_pkg::CSR_DEATH_LIMIT: death_ff <= csr_data[cags_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      col_wide = CMPW'(col_count_ff);
      if (row_count_ff == '0) begin
         rows_eff = RW'(1);
      end else if (row_count_ff > RW'(cags_pkg::MAX_ROWS)) begin
         rows_eff = RW'(cags_pkg::MAX_ROWS);
      end else begin
         rows_eff = row_count_ff;
      end
      if (col_count_ff == '0) begin
         cols_eff = CW'(1);
      end else if (col_wide > CMPW'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = col_wide[CW-1:0];
      end
   end

   // ---------------- first stage: position and drain control ----------------
   assign accept     = req_valid && req_ready;
   assign draining   = drain_ff != '0;
   assign take_drop  = accept && !req_flush && draining;
   assign take_proc  = accept && (req_flush == draining);
   assign ci_last    = ((CW+1)'(in_col_ff) + (CW+1)'(1)) >= (CW+1)'(cols_eff);
   assign ri_last    = ((RW+1)'(in_row_ff) + (RW+1)'(1)) >= (RW+1)'(rows_eff);
   assign emit       = (in_row_ff >= RW'(2)) || (in_row_ff == RW'(1) && in_col_ff != '0);
   assign frame_last = req_flush && drain_ff == DW'(1);

   assign border.first_col = out_col_ff == '0;
   assign border.last_col  = ((CW+1)'(out_col_ff) + (CW+1)'(1)) >= (CW+1)'(cols_eff);
   assign border.first_row = out_row_ff == '0;
   assign border.last_row  = ((RW+1)'(out_row_ff) + (RW+1)'(1)) >= (RW+1)'(rows_eff);

   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      drain_in   = drain_ff;
      if (geom_write) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         drain_in   = '0;
      end else if (take_proc) begin
         if (ci_last) begin
            in_col_in = '0;
            in_row_in = in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
         if (!req_flush) begin
            if (ri_last && ci_last) begin
               drain_in = DW'(cols_eff) + DW'(1);
            end
         end else begin
            drain_in = drain_ff - DW'(1);
         end
         if (emit) begin
            if (border.last_col) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
         if (frame_last) begin
            in_row_in  = '0;
            in_col_in  = '0;
            out_row_in = '0;
            out_col_in = '0;
            drain_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         drain_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s1_mem_ff   <= 1'b0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         drain_ff    <= drain_in;
         s1_valid_ff <= take_drop || (take_proc && emit);
         s1_mem_ff   <= take_proc;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_dropped_ff <= take_drop;
         s1_last_ff    <= frame_last;
         s1_bit_ff     <= !req_flush && req_cell_alive;
         s1_addr_ff    <= in_col_ff[AW-1:0];
         s1_border_ff  <= border;
      end
   end

   // ---------------- line buffers ----------------
   // bit 0: two rows above, bit 1: one row above
   cags_ram #(
      .WIDTH (2),
      .DEPTH (MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_mem_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wr),
      .rd_en   (take_proc),
      .rd_addr (in_col_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // bypass the previous beat's write when it went to the same column as this beat's read
   assign line_rd = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : ram_rd_data;
   assign line_wr = {s1_bit_ff, line_rd[1]};

   always_comb begin
      window_in = window_ff;
      if (s1_mem_ff) begin
         window_in = {s1_bit_ff, line_rd[1], line_rd[0],
                      window_ff[cags_pkg::WINDOW_W-1:3]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         fwd_valid_ff <= s1_mem_ff;
      end
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= line_wr;
   end

   // ---------------- second stage: rule and output ----------------
   cags_rule u_rule (
      .window      (window_in),
      .border      (s1_border_ff),
      .birth_limit (birth_ff),
      .death_limit (death_ff),
      .next_alive  (rule_alive)
   );

   always_comb begin
      if (s1_dropped_ff) begin
         s1_result.next_alive    = 1'b0;
         s1_result.last_of_frame = 1'b0;
         s1_result.dropped       = 1'b1;
      end else begin
         s1_result.next_alive    = rule_alive;
         s1_result.last_of_frame = s1_last_ff;
         s1_result.dropped       = 1'b0;
      end
   end

   assign pop = q_not_empty && rsp_ready;

   cags_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_result),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (q_head),
      .count     (q_count)
   );

   // leave room in the queue for the beat in flight and the one taken now
   assign req_ready = ((cags_pkg::Q_COUNT_W+1)'(q_count) + (cags_pkg::Q_COUNT_W+1)'(s1_valid_ff))
                      < (cags_pkg::Q_COUNT_W+1)'(cags_pkg::Q_DEPTH);

   assign rsp_valid         = q_not_empty;
   assign rsp_next_alive    = q_head.next_alive;
   assign rsp_last_of_frame = q_head.last_of_frame;
   assign rsp_dropped       = q_head.dropped;

`ifndef SYNTH
   a_queue_no_overflow : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (q_count != cags_pkg::Q_COUNT_W'(cags_pkg::Q_DEPTH) || rsp_ready))
      else $error("response queue overflow");

   a_drop_during_drain : assert property (@(posedge clock) disable iff (reset)
      (take_drop) |=> (s1_valid_ff && s1_dropped_ff && !s1_mem_ff))
      else $error("cell during drain not answered as dropped");

   a_col_in_range : assert property (@(posedge clock) disable iff (reset)
      take_proc |-> (in_col_ff < cols_eff))
      else $error("line buffer column out of range");

   a_drain_bounded : assert property (@(posedge clock) disable iff (reset)
      (drain_ff != '0) |-> ((CW+1)'(drain_ff) <= (CW+1)'(cols_eff) + (CW+1)'(1)))
      else $error("drain count beyond one row and one cell");
`endif

endmodule
